FILE: rtl/bdk_pkg.sv
// Package for the bounded ordered list with delete by key.
// Holds the sizes, the request and cell command codes, and the shared structs.
// No dependencies.
`timescale 1ns / 1ps

package bdk_pkg;

  // Number of entries the list can hold.
  localparam int CAPACITY = 128;

  // Field widths of one entry and of the reported count.
  localparam int KEY_W = 32;
  localparam int PAY_W = 32;
  localparam int CNT_W = 8;

  // Width of a cell position and of the internal entry count (0..CAPACITY).
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Grouping of the registered selection tree for remove by key.
  localparam int SEL_GRP  = 16;
  localparam int SEL_NGRP = (CAPACITY + SEL_GRP - 1) / SEL_GRP;

  // Request codes.
  typedef enum logic [1:0] {
    ACT_PUSH_BACK  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_REMOVE_KEY = 2'd3
  } act_t;

  // Command broadcast to every cell in the chain.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP,
    OP_COMPARE,
    OP_REMOVE
  } op_t;

  // One stored entry.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  // Broadcast command with the request operands and the current count.
  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [CW-1:0]    cnt;
  } cmd_t;

endpackage

FILE: rtl/bdk_ifs.sv
// Request and response channel interfaces for the bounded ordered list.
// Each carries valid, ready and the transaction payload. Depends on bdk_pkg.
`timescale 1ns / 1ps

interface bdk_req_if import bdk_pkg::*; ();
  logic             valid;
  logic             ready;
  act_t             action;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;

  modport source (output valid, action, key, payload, input ready);
  modport sink (input valid, action, key, payload, output ready);
endinterface

interface bdk_rsp_if import bdk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             ok;
  logic [KEY_W-1:0] entry_key;
  logic [PAY_W-1:0] entry_payload;
  logic [CNT_W-1:0] count;

  modport source (output valid, ok, entry_key, entry_payload, count, input ready);
  modport sink (input valid, ok, entry_key, entry_payload, count, output ready);
endinterface

FILE: rtl/bdk_cell.sv
// One cell of the shift list: holds one entry and a match flag.
// Shifts with its neighbors on push front, pop and removal. Depends on bdk_pkg.
`timescale 1ns / 1ps

module bdk_cell import bdk_pkg::*; (
  input  logic          clk,
  input  cmd_t          cmd,
  input  logic [AW-1:0] idx,
  input  entry_t        left,
  input  entry_t        right,
  input  logic          pfx_in,
  output entry_t        cur,
  output logic          pfx_out,
  output logic          first_hit
);

  entry_t data;
  logic   hit;
  logic   at_tail;
  logic   occupied;

  // Position of this cell relative to the fill level.
  assign at_tail  = (CW'(idx) == cmd.cnt);
  assign occupied = (CW'(idx) < cmd.cnt);

  // A match at or before this cell means this cell closes the gap.
  assign pfx_out   = pfx_in | hit;
  assign first_hit = hit & ~pfx_in;
  assign cur       = data;

  // Entry and match flag update for each broadcast command.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_PUSH_BACK: begin
        if (at_tail) begin
          data <= '{key: cmd.key, payload: cmd.payload};
        end
      end
      OP_PUSH_FRONT: begin
        data <= left;
      end
      OP_POP: begin
        data <= right;
      end
      OP_COMPARE: begin
        hit <= occupied && (data.key == cmd.key);
      end
      OP_REMOVE: begin
        if (pfx_out) begin
          data <= right;
        end
      end
      OP_HOLD: begin
      end
    endcase
  end

endmodule

FILE: rtl/bdk_sel_reduce.sv
// Registered AND-OR tree that picks the payload of the selected cell.
// First level is registered per group of cells. Depends on bdk_pkg.
`timescale 1ns / 1ps

module bdk_sel_reduce import bdk_pkg::*; (
  input  logic             clk,
  input  logic [CAPACITY-1:0] sel,
  input  logic [PAY_W-1:0] pay [CAPACITY],
  output logic [PAY_W-1:0] data
);

  logic [PAY_W-1:0] grp_or [SEL_NGRP];
  logic [PAY_W-1:0] grp_q  [SEL_NGRP];

  // Masked OR within each group of cells.
  always_comb begin
    for (int g = 0; g < SEL_NGRP; g++) begin
      grp_or[g] = '0;
      for (int j = 0; j < SEL_GRP; j++) begin
        if (g * SEL_GRP + j < CAPACITY) begin
          if (sel[g * SEL_GRP + j]) begin
            grp_or[g] = grp_or[g] | pay[g * SEL_GRP + j];
          end
        end
      end
    end
  end

  // Group results are registered before the final merge.
  always_ff @(posedge clk) begin
    for (int g = 0; g < SEL_NGRP; g++) begin
      grp_q[g] <= grp_or[g];
    end
  end

  // Final merge across the groups.
  always_comb begin
    data = '0;
    for (int g = 0; g < SEL_NGRP; g++) begin
      data = data | grp_q[g];
    end
  end

endmodule

FILE: rtl/bounded_deque_with_key_removal.sv
// Top level of the bounded ordered list with delete by key.
// Uses bdk_pkg, bdk_ifs, bdk_cell and bdk_sel_reduce.
`timescale 1ns / 1ps

// The list is a chain of CAPACITY cells, front at cell 0, that shift entries
// toward the back on push front and toward the front on pop or removal. One
// request transaction is handled at a time. Push back, push front and pop
// front pass through an execute state, in which the cell chain acts and the
// result is registered, then a done state that loads the response register.
// Remove by key passes through compare, select, gather and done states: the
// cells compare their keys, the first match closes the gap while a group
// register in the tree captures its payload, the tree's final merge is
// registered as the result payload, and the response register loads. A
// finished response waits in its output register, and a new request may be
// accepted meanwhile; a second response that finds the register still
// occupied holds the block until the first one is taken. The response count
// is the low eight bits of the number of entries held.

module bounded_deque_with_key_removal import bdk_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  bdk_req_if.sink        req,
  bdk_rsp_if.source      rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CMP,
    S_SEL,
    S_GATH,
    S_DONE
  } state_t;

  state_t           state;
  logic [CW-1:0]    cnt;
  act_t             req_act;
  logic [KEY_W-1:0] req_key;
  logic [PAY_W-1:0] req_pay;
  logic             res_ok;
  logic [KEY_W-1:0] res_key;
  logic [PAY_W-1:0] res_pay;
  logic             rsp_valid;
  logic             rsp_ok;
  logic [KEY_W-1:0] rsp_key;
  logic [PAY_W-1:0] rsp_pay;
  logic [CNT_W-1:0] rsp_count;

  logic             full;
  logic             empty;
  cmd_t             cmd;
  entry_t           head_in;
  entry_t           cell_q  [CAPACITY];
  entry_t           left_w  [CAPACITY];
  entry_t           right_w [CAPACITY];
  logic [PAY_W-1:0] pay_vec [CAPACITY];
  logic [CAPACITY:0]   pfx;
  logic [CAPACITY-1:0] first_hit;
  logic [PAY_W-1:0] sel_data;

  assign full  = (cnt == CW'(CAPACITY));
  assign empty = (cnt == '0);

  // Command broadcast to the cell chain.
  always_comb begin
    cmd.key     = req_key;
    cmd.payload = req_pay;
    cmd.cnt     = cnt;
    cmd.op      = OP_HOLD;
    unique case (state)
      S_EXEC: begin
        unique case (req_act)
          ACT_PUSH_BACK:  cmd.op = full ? OP_HOLD : OP_PUSH_BACK;
          ACT_PUSH_FRONT: cmd.op = full ? OP_HOLD : OP_PUSH_FRONT;
          ACT_POP_FRONT:  cmd.op = empty ? OP_HOLD : OP_POP;
          ACT_REMOVE_KEY: cmd.op = OP_HOLD;
        endcase
      end
      S_CMP:  cmd.op = OP_COMPARE;
      S_SEL:  cmd.op = OP_REMOVE;
      S_IDLE, S_GATH, S_DONE: cmd.op = OP_HOLD;
    endcase
  end

  // A push front enters the chain at the head.
  assign head_in = '{key: req_key, payload: req_pay};
  assign pfx[0]  = 1'b0;

  // The chain of cells, each linked to both neighbors.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_w[g] = head_in;
    end else begin : g_mid
      assign left_w[g] = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w[g] = '0;
    end else begin : g_body
      assign right_w[g] = cell_q[g+1];
    end

    bdk_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (AW'(g)),
      .left      (left_w[g]),
      .right     (right_w[g]),
      .pfx_in    (pfx[g]),
      .cur       (cell_q[g]),
      .pfx_out   (pfx[g+1]),
      .first_hit (first_hit[g])
    );

    assign pay_vec[g] = cell_q[g].payload;
  end

  // Payload of the first matching cell, captured as the gap closes.
  bdk_sel_reduce u_sel (
    .clk  (clk),
    .sel  (first_hit),
    .pay  (pay_vec),
    .data (sel_data)
  );

  // Control sequence, entry count and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_act <= req.action;
            req_key <= req.key;
            req_pay <= req.payload;
            state   <= (req.action == ACT_REMOVE_KEY) ? S_CMP : S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (req_act)
            ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
              res_ok  <= ~full;
              res_key <= full ? '0 : req_key;
              res_pay <= full ? '0 : req_pay;
              if (!full) begin
                cnt <= cnt + CW'(1);
              end
            end
            ACT_POP_FRONT: begin
              res_ok  <= ~empty;
              res_key <= empty ? '0 : cell_q[0].key;
              res_pay <= empty ? '0 : cell_q[0].payload;
              if (!empty) begin
                cnt <= cnt - CW'(1);
              end
            end
            ACT_REMOVE_KEY: begin
              res_ok  <= 1'b0;
              res_key <= '0;
              res_pay <= '0;
            end
          endcase
          state <= S_DONE;
        end
        S_CMP: begin
          state <= S_SEL;
        end
        S_SEL: begin
          res_ok  <= pfx[CAPACITY];
          res_key <= pfx[CAPACITY] ? req_key : '0;
          if (pfx[CAPACITY]) begin
            cnt <= cnt - CW'(1);
          end
          state <= S_GATH;
        end
        S_GATH: begin
          res_pay <= res_ok ? sel_data : '0;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_ok    <= res_ok;
            rsp_key   <= res_key;
            rsp_pay   <= res_pay;
            rsp_count <= CNT_W'(cnt);
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE) && !rst;
  assign rsp.valid         = rsp_valid;
  assign rsp.ok            = rsp_ok;
  assign rsp.entry_key     = rsp_key;
  assign rsp.entry_payload = rsp_pay;
  assign rsp.count         = rsp_count;

  // The fill level never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // The count only moves in the cycles where the chain inserts or removes.
  a_cnt_move: assert property (@(posedge clk) disable iff (rst)
    (!$stable(cnt) && !$past(rst)) |-> ($past(state) == S_EXEC || $past(state) == S_SEL))
    else $error("entry count changed outside an update cycle");

  // At most one cell is the first match during removal.
  a_first_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEL) |-> $onehot0(first_hit))
    else $error("more than one first match in the chain");

  // A failed transaction reports an empty entry.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ok) |-> (rsp_key == '0 && rsp_pay == '0))
    else $error("failed response carries entry data");

endmodule

FILE: sim/bounded_deque_with_key_removal_test.sv
// Self-checking testbench for bounded_deque_with_key_removal: random and directed requests,
// with an in-bench list predictor and an in-order scoreboard on the response channel.
// Depends on bdk_pkg, bdk_ifs and the RTL of the block.
`timescale 1ns / 1ps

module bounded_deque_with_key_removal_test;
  import bdk_pkg::*;

  localparam int IDLE_PCT       = 34;
  localparam int CALM_FIRST     = 1800;
  localparam int CALM_LAST      = 2600;
  localparam int HOLD_START     = 700;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int POOL_SIZE      = 16;

  // One request transaction waiting to be driven.
  typedef struct {
    act_t             act;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } request_t;

  // One response transaction as predicted or observed.
  typedef struct {
    logic             ok;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [CNT_W-1:0] count;
  } response_t;

  logic clk;
  logic rst;

  bdk_req_if req_ch ();
  bdk_rsp_if rsp_ch ();

  bounded_deque_with_key_removal DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  request_t         request_q[$];
  response_t        expected_rsp_q[$];
  entry_t           held_entries[$];
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  bit req_taken   = 1'b0;
  int cycle_n     = 0;
  int idle_run    = 0;
  int accepted_n  = 0;
  int error_n     = 0;
  int hold_left   = 0;
  int act_n[4]    = '{0, 0, 0, 0};
  int full_n      = 0;
  int empty_n     = 0;
  int miss_n      = 0;
  int peak_count  = 0;
  logic calm;

  // Both sides stop idling for one stretch of the run.
  assign calm = (cycle_n >= CALM_FIRST) && (cycle_n < CALM_LAST);

  always #5 clk = ~clk;

  // Apply one request to the held list and return the response it should give.
  function automatic response_t apply_request(act_t act, logic [KEY_W-1:0] k,
                                              logic [PAY_W-1:0] p);
    response_t r;
    int        hit;
    r   = '{ok: 1'b0, key: '0, payload: '0, count: '0};
    hit = -1;
    case (act)
      ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
        if (held_entries.size() < CAPACITY) begin
          if (act == ACT_PUSH_BACK) held_entries.push_back('{key: k, payload: p});
          else held_entries.push_front('{key: k, payload: p});
          r.ok      = 1'b1;
          r.key     = k;
          r.payload = p;
        end
      end
      ACT_POP_FRONT: begin
        if (held_entries.size() != 0) begin
          r.ok      = 1'b1;
          r.key     = held_entries[0].key;
          r.payload = held_entries[0].payload;
          void'(held_entries.pop_front());
        end
      end
      default: begin
        // Only the match nearest the front is taken out.
        for (int i = 0; i < held_entries.size(); i++) begin
          if (hit < 0 && held_entries[i].key == k) hit = i;
        end
        if (hit >= 0) begin
          r.ok      = 1'b1;
          r.key     = held_entries[hit].key;
          r.payload = held_entries[hit].payload;
          held_entries.delete(hit);
        end
      end
    endcase
    r.count = CNT_W'(held_entries.size());
    return r;
  endfunction

  task automatic add_request(act_t act, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
    request_q.push_back('{act: act, key: k, payload: p});
  endtask

  // A run of random requests; push_pct sets how often an insert is chosen,
  // and most keys come from a small pool so that removals find matches.
  task automatic add_random_run(int n, int push_pct);
    act_t             act;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < push_pct)
        act = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      else
        act = $urandom_range(1) ? ACT_REMOVE_KEY : ACT_POP_FRONT;
      k = ($urandom_range(99) < 80) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
      add_request(act, k, $urandom);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_n++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Request driver: a new transaction is offered once the previous one is taken.
  always @(negedge clk) begin : drive_requests
    request_t next_req;
    if (!rst && (!req_ch.valid || req_taken)) begin
      if (request_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        next_req       = request_q.pop_front();
        req_ch.valid   <= 1'b1;
        req_ch.action  <= next_req.act;
        req_ch.key     <= next_req.key;
        req_ch.payload <= next_req.payload;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response ready, with one long hold-off so that the block backs up.
  always @(negedge clk) begin : drive_ready
    if (!rst) begin
      if (cycle_n == HOLD_START) hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Monitor: check responses in order, predict for each accepted request.
  always @(posedge clk) begin : monitor
    response_t want;
    if (!rst) begin
      cycle_n++;
      idle_run++;

      if (rsp_ch.valid && rsp_ch.ready) begin
        idle_run = 0;
        if (expected_rsp_q.size() == 0) begin
          error_n++;
          $display("%0t: unexpected response, expected none, got ok=%0b key=%h payload=%h count=%0d",
                   $time, rsp_ch.ok, rsp_ch.entry_key, rsp_ch.entry_payload, rsp_ch.count);
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("ok", 32'(want.ok), 32'(rsp_ch.ok));
          check_field("entry_key", want.key, rsp_ch.entry_key);
          check_field("entry_payload", want.payload, rsp_ch.entry_payload);
          check_field("count", 32'(want.count), 32'(rsp_ch.count));
        end
      end

      req_taken = req_ch.valid && req_ch.ready;
      if (req_taken) begin
        idle_run = 0;
        accepted_n++;
        want = apply_request(req_ch.action, req_ch.key, req_ch.payload);
        expected_rsp_q.push_back(want);
        act_n[req_ch.action]++;
        if (want.count > peak_count) peak_count = want.count;
        if (!want.ok) begin
          case (req_ch.action)
            ACT_PUSH_BACK, ACT_PUSH_FRONT: full_n++;
            ACT_POP_FRONT: empty_n++;
            default: miss_n++;
          endcase
        end
      end

      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_run);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int total_n;
    clk            = 1'b0;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.action  = ACT_PUSH_BACK;
    req_ch.key     = '0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;

    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // Directed part: empty list, field extremes, duplicate keys, misses.
    add_request(ACT_POP_FRONT, 32'h0, 32'h0);
    add_request(ACT_REMOVE_KEY, 32'h0, $urandom);
    add_request(ACT_PUSH_BACK, 32'h0, 32'h0);
    add_request(ACT_PUSH_BACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(ACT_PUSH_FRONT, 32'h5A5A_A5A5, 32'h1);
    add_request(ACT_PUSH_FRONT, 32'h5A5A_A5A5, 32'h2);
    add_request(ACT_PUSH_BACK, 32'h5A5A_A5A5, 32'h3);
    add_request(ACT_REMOVE_KEY, 32'h5A5A_A5A5, $urandom);
    add_request(ACT_REMOVE_KEY, 32'h5A5A_A5A5, $urandom);
    add_request(ACT_REMOVE_KEY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(ACT_REMOVE_KEY, 32'h1234_5678, 32'h0);
    add_request(ACT_POP_FRONT, 32'hFFFF_FFFF, $urandom);
    add_request(ACT_POP_FRONT, $urandom, $urandom);
    add_request(ACT_POP_FRONT, $urandom, 32'hFFFF_FFFF);
    add_request(ACT_PUSH_FRONT, 32'h8000_0001, 32'h7FFF_FFFE);
    add_request(ACT_REMOVE_KEY, 32'h8000_0001, 32'h0);
    add_request(ACT_REMOVE_KEY, 32'h8000_0001, 32'h0);

    // Random part: fill to full, churn, drain to empty, and once more.
    add_random_run(200, 90);
    add_random_run(200, 50);
    add_random_run(200, 10);
    add_random_run(150, 92);
    add_random_run(150, 20);
    total_n = request_q.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_n < total_n || expected_rsp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d push back, %0d push front, %0d pop, %0d remove; peak depth %0d.",
             accepted_n, act_n[ACT_PUSH_BACK], act_n[ACT_PUSH_FRONT], act_n[ACT_POP_FRONT],
             act_n[ACT_REMOVE_KEY], peak_count);
    $display("Refused: %0d inserts on a full list, %0d pops on empty, %0d removals with no match.",
             full_n, empty_n, miss_n);
    if (error_n == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
